// ===== rtl/mlfd_pkg.sv =====
// Shared types, codes and constants for the magic/length frame deframer.
package mlfd_pkg;

   localparam int SizeWidth = 21;
   localparam logic [SizeWidth-1:0] MAX_FRAME_SIZE_RESET = SizeWidth'(60 * 1024);

   localparam logic [7:0] MAGIC_0 = 8'hAA;
   localparam logic [7:0] MAGIC_1 = 8'hBB;
   localparam logic [7:0] MAGIC_2 = 8'hCC;
   localparam logic [7:0] MAGIC_3 = 8'hDD;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_EOF  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD   = 2'd0,
      EV_BAD_MAGIC = 2'd1,
      EV_BAD_SIZE  = 2'd2,
      EV_TRUNCATED = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_RESYNC  = 3'd1,
      PH_SIZE    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_SKIP    = 3'd4
   } phase_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] payload_byte;
      logic       frame_last;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } parse_result_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0: value = MAGIC_0;
         2'd1: value = MAGIC_1;
         2'd2: value = MAGIC_2;
         2'd3: value = MAGIC_3;
         default: value = MAGIC_0;
      endcase
      return value;
   endfunction

endpackage

// ===== rtl/mlfd_parser.sv =====
// Header parser state machine: decodes one item per step and produces at most one result.
module mlfd_parser
   import mlfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  req_item_type         item,
   input  logic [SizeWidth-1:0] max_frame_size,
   output parse_result_type     result
);

   phase_type            phase_ff, phase_in;
   logic [2:0]           header_count_ff, header_count_in;
   logic                 magic_bad_ff, magic_bad_in;
   logic [1:0]           magic_match_ff, magic_match_in;
   logic [31:0]          size_value_ff, size_value_in;
   logic [SizeWidth-1:0] bytes_left_ff, bytes_left_in;

   logic                 is_eof;
   logic [31:0]          size_update;
   logic                 size_bad;
   logic                 header_hit;
   logic                 resync_hit;
   logic                 magic_bad_update;
   logic                 header_done;
   logic                 size_done;
   logic                 payload_last;

   always_comb begin
      size_update = size_value_ff;
      case (header_count_ff[1:0])
         2'd0: size_update[7:0]   = item.data_byte;
         2'd1: size_update[15:8]  = item.data_byte;
         2'd2: size_update[23:16] = item.data_byte;
         2'd3: size_update[31:24] = item.data_byte;
         default: size_update = size_value_ff;
      endcase
   end

   assign is_eof           = (item.op == OP_EOF);
   assign size_bad         = (size_update == 32'd0) ||
                             (size_update > {{(32 - SizeWidth){1'b0}}, max_frame_size});
   assign header_hit       = (item.data_byte == magic_byte(header_count_ff[1:0]));
   assign resync_hit       = (item.data_byte == magic_byte(magic_match_ff));
   assign magic_bad_update = magic_bad_ff | (!header_count_ff[2] & !header_hit);
   assign header_done      = (header_count_ff == 3'd7);
   assign size_done        = (header_count_ff == 3'd3);
   assign payload_last     = (bytes_left_ff == SizeWidth'(1));

   // Next state.
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      magic_bad_in    = magic_bad_ff;
      magic_match_in  = magic_match_ff;
      size_value_in   = size_value_ff;
      bytes_left_in   = bytes_left_ff;
      if (is_eof) begin
         phase_in        = PH_HEADER;
         header_count_in = 3'd0;
         magic_bad_in    = 1'b0;
         magic_match_in  = 2'd0;
         size_value_in   = 32'd0;
         bytes_left_in   = '0;
      end else begin
         case (phase_ff)
            PH_RESYNC: begin
               if (resync_hit) begin
                  magic_match_in = magic_match_ff + 2'd1;
                  if (magic_match_ff == 2'd3) begin
                     magic_match_in  = 2'd0;
                     header_count_in = 3'd0;
                     size_value_in   = 32'd0;
                     phase_in        = PH_SIZE;
                  end
               end else begin
                  magic_match_in = (item.data_byte == MAGIC_0) ? 2'd1 : 2'd0;
               end
            end
            PH_SIZE: begin
               size_value_in   = size_update;
               header_count_in = header_count_ff + 3'd1;
               if (size_done) begin
                  header_count_in = 3'd0;
                  if (size_bad) begin
                     phase_in = PH_SKIP;
                  end else begin
                     bytes_left_in = size_update[SizeWidth-1:0];
                     phase_in      = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               bytes_left_in = bytes_left_ff - SizeWidth'(1);
               if (payload_last) begin
                  phase_in        = PH_HEADER;
                  header_count_in = 3'd0;
                  magic_bad_in    = 1'b0;
                  magic_match_in  = 2'd0;
                  size_value_in   = 32'd0;
                  bytes_left_in   = '0;
               end
            end
            PH_SKIP: begin
               phase_in = PH_SKIP;
            end
            default: begin
               phase_in        = PH_HEADER;
               header_count_in = header_count_ff + 3'd1;
               if (header_count_ff[2]) begin
                  size_value_in = size_update;
               end else begin
                  magic_bad_in = magic_bad_update;
               end
               if (header_done) begin
                  header_count_in = 3'd0;
                  if (magic_bad_update) begin
                     magic_bad_in   = 1'b0;
                     magic_match_in = 2'd0;
                     size_value_in  = 32'd0;
                     phase_in       = PH_RESYNC;
                  end else if (size_bad) begin
                     phase_in = PH_SKIP;
                  end else begin
                     bytes_left_in = size_update[SizeWidth-1:0];
                     phase_in      = PH_PAYLOAD;
                  end
               end
            end
         endcase
      end
   end

   // Result for the current item.
   always_comb begin
      result = '0;
      if (is_eof) begin
         if (phase_ff == PH_PAYLOAD) begin
            result.valid          = 1'b1;
            result.item.event_res = EV_TRUNCATED;
         end
      end else begin
         case (phase_ff)
            PH_RESYNC, PH_SKIP: begin
               result.valid = 1'b0;
            end
            PH_SIZE: begin
               if (size_done && size_bad) begin
                  result.valid          = 1'b1;
                  result.item.event_res = EV_BAD_SIZE;
               end
            end
            PH_PAYLOAD: begin
               result.valid             = 1'b1;
               result.item.event_res    = EV_PAYLOAD;
               result.item.payload_byte = item.data_byte;
               result.item.frame_last   = payload_last;
            end
            default: begin
               if (header_done) begin
                  if (magic_bad_update) begin
                     result.valid          = 1'b1;
                     result.item.event_res = EV_BAD_MAGIC;
                  end else if (size_bad) begin
                     result.valid          = 1'b1;
                     result.item.event_res = EV_BAD_SIZE;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= 3'd0;
         magic_bad_ff    <= 1'b0;
         magic_match_ff  <= 2'd0;
         size_value_ff   <= 32'd0;
         bytes_left_ff   <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         magic_bad_ff    <= magic_bad_in;
         magic_match_ff  <= magic_match_in;
         size_value_ff   <= size_value_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

   // A frame in flight always has at least one byte left.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (bytes_left_ff != '0))
      else $error("payload phase with no bytes left");

   // Size collection after a resync never goes past the fourth byte.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SIZE) |-> !header_count_ff[2])
      else $error("size byte count out of range");

   // A bad magic report always starts the hunt.
   assert property (@(posedge clock) disable iff (reset)
      (step && result.valid && (result.item.event_res == EV_BAD_MAGIC))
         |=> (phase_ff == PH_RESYNC) && (magic_match_ff == 2'd0))
      else $error("bad magic without resync");

   // End of file always returns the parser to a clean header search.
   assert property (@(posedge clock) disable iff (reset)
      (step && is_eof) |=> (phase_ff == PH_HEADER) && (header_count_ff == 3'd0)
         && !magic_bad_ff)
      else $error("parser not cleared at end of file");

endmodule

// ===== rtl/magic_length_frame_deframer_top.sv =====
// Top level of the magic/length frame deframer: input register, parser and result register.
//
// The req channel carries one file byte per item (op data) or an end-of-file
// item (op eof). Each frame in the file is the magic AA BB CC DD, a
// little-endian 32-bit payload size and then the payload. The rsp channel
// returns one item per payload byte, with frame_last on the final byte, and
// one item for each error: bad magic (a byte-wise hunt follows), invalid size
// (data is ignored until end of file) or a frame truncated by end of file.
// An item enters the input register and is decoded there by the parser. When it
// advances, its result lands in the result register, which drives rsp_valid.
// One item is taken every cycle while the rsp side does not stall. When
// rsp_stall is high with a result waiting, the item in the input register stays
// and req_stall rises in that same cycle. If the input register is empty, one
// more item is still taken. Reset clears both registers and the parser, and
// sets max_frame_size to 61440. Write csr only while no item is in flight; a
// write takes effect at the next edge.
module magic_length_frame_deframer_top
   import mlfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_item,
   input  logic                 csr_wr_en,
   input  logic [SizeWidth-1:0] csr_wr_data
);

   logic                 in_valid_ff, in_valid_in;
   req_item_type         in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_item_type         out_item_ff;
   logic [SizeWidth-1:0] max_size_ff;

   logic                 advance;
   logic                 req_take;
   parse_result_type     result;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? result.valid : (out_valid_ff && rsp_stall);

   mlfd_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .item           (in_item_ff),
      .max_frame_size (max_size_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_size_ff  <= MAX_FRAME_SIZE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            max_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance && result.valid) begin
         out_item_ff <= result.item;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // A waiting result is never overwritten while the receiver stalls.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !advance)
      else $error("result register overwritten under stall");

   // A held input item is processed before a new one is taken.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_take)
      else $error("input register overwritten before processing");

   // Every result leaving the parser reaches the result register.
   assert property (@(posedge clock) disable iff (reset)
      (advance && result.valid) |=> out_valid_ff)
      else $error("parser result lost");

endmodule

// ===== sim/tb_magic_length_frame_deframer_top.sv =====
// Self-checking testbench for the magic/length frame deframer top level.
import mlfd_pkg::*;

localparam logic [3:0][7:0] MAGIC_WORD = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};

class frame_event_checker;
   rsp_item_type expected_events[$];
   int failures;
   logic [SizeWidth-1:0] max_frame_size;
   phase_type phase;
   logic [2:0] header_count;
   logic magic_bad;
   logic [2:0] magic_match;
   logic [31:0] size_value;
   logic [SizeWidth-1:0] bytes_left;

   function new();
      failures = 0;
      max_frame_size = MAX_FRAME_SIZE_RESET;
      restart_parse();
   endfunction

   function void restart_parse();
      phase = PH_HEADER;
      header_count = '0;
      magic_bad = 1'b0;
      magic_match = '0;
      size_value = '0;
      bytes_left = '0;
   endfunction

   function void push_event(event_type ev, logic [7:0] b, logic last);
      rsp_item_type r;
      r.event_res = ev;
      r.payload_byte = b;
      r.frame_last = last;
      expected_events.push_back(r);
   endfunction

   function void close_size();
      header_count = '0;
      if (size_value == 32'd0 || size_value > 32'(max_frame_size)) begin
         phase = PH_SKIP;
         push_event(EV_BAD_SIZE, 8'h00, 1'b0);
      end else begin
         bytes_left = size_value[SizeWidth-1:0];
         phase = PH_PAYLOAD;
      end
   endfunction

   function void take_file_item(req_item_type it);
      if (it.op == OP_EOF) begin
         if (phase == PH_PAYLOAD) push_event(EV_TRUNCATED, 8'h00, 1'b0);
         restart_parse();
         return;
      end
      case (phase)
         PH_RESYNC: begin
            if (it.data_byte == MAGIC_WORD[magic_match[1:0]]) begin
               magic_match = magic_match + 3'd1;
               if (magic_match >= 3'd4) begin
                  magic_match = '0;
                  header_count = '0;
                  size_value = '0;
                  phase = PH_SIZE;
               end
            end else begin
               magic_match = (it.data_byte == MAGIC_WORD[0]) ? 3'd1 : 3'd0;
            end
         end
         PH_SIZE: begin
            size_value[8*header_count[1:0] +: 8] = it.data_byte;
            header_count = header_count + 3'd1;
            if (header_count >= 3'd4) close_size();
         end
         PH_PAYLOAD: begin
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == '0) begin
               restart_parse();
               push_event(EV_PAYLOAD, it.data_byte, 1'b1);
            end else begin
               push_event(EV_PAYLOAD, it.data_byte, 1'b0);
            end
         end
         PH_SKIP: ;
         default: begin
            phase = PH_HEADER;
            if (header_count < 3'd4) begin
               if (it.data_byte != MAGIC_WORD[header_count[1:0]]) magic_bad = 1'b1;
            end else begin
               size_value[8*header_count[1:0] +: 8] = it.data_byte;
            end
            header_count = header_count + 3'd1;
            if (header_count == 3'd0) begin
               if (magic_bad) begin
                  magic_bad = 1'b0;
                  magic_match = '0;
                  size_value = '0;
                  phase = PH_RESYNC;
                  push_event(EV_BAD_MAGIC, 8'h00, 1'b0);
               end else begin
                  close_size();
               end
            end
         end
      endcase
   endfunction

   function void check_event(rsp_item_type got);
      rsp_item_type want;
      if (expected_events.size() == 0) begin
         $error("unexpected item: event_res %0d, payload_byte %02h, frame_last %0d",
                got.event_res, got.payload_byte, got.frame_last);
         failures++;
         return;
      end
      want = expected_events.pop_front();
      if (got.event_res !== want.event_res) begin
         $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
         failures++;
      end
      if (got.payload_byte !== want.payload_byte) begin
         $error("payload_byte: expected %02h, actual %02h", want.payload_byte, got.payload_byte);
         failures++;
      end
      if (got.frame_last !== want.frame_last) begin
         $error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
         failures++;
      end
   endfunction

   function int outstanding();
      return expected_events.size();
   endfunction
endclass

module tb_magic_length_frame_deframer_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 250;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [SizeWidth-1:0] csr_wr_data = '0;

   frame_event_checker checker_sb = new();
   int cycle_count = 0;
   int items_sent = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int cur_max = MAX_FRAME_SIZE_RESET;
   bit hold_toggle = 1'b0;

   magic_length_frame_deframer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_magic_length_frame_deframer_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_valid && !req_stall) checker_sb.take_file_item(req_item);
         if (rsp_valid && !rsp_stall) checker_sb.check_event(rsp_item);
      end
   end

   initial begin
      bit seen;
      int hold_left;
      seen = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_toggle != seen) begin
            seen = hold_toggle;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input op_type op, input logic [7:0] b, input bit counted);
      req_item_type it;
      it.op = op;
      it.data_byte = b;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      if (counted) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(OP_DATA, b, 1'b1);
   endtask

   task automatic send_eof();
      send_item(OP_EOF, 8'($urandom), 1'b1);
   endtask

   // Bytes of a header word: magic in the low four bytes, size above.
   task automatic send_bytes(input logic [63:0] v, input int first, input int count);
      int i;
      for (i = first; i < first + count; i++) send_byte(v[8*i +: 8]);
   endtask

   task automatic send_body(input logic [31:0] size, input int cut);
      int i;
      if (size == 32'd0 || size > cur_max) begin
         repeat ($urandom_range(4)) send_item(OP_DATA, 8'($urandom), 1'b0);
         send_eof();
         return;
      end
      for (i = 0; i < size; i++) begin
         if (i == cut) begin
            send_eof();
            return;
         end
         send_byte(8'($urandom));
      end
   endtask

   task automatic send_bad_header();
      int k, i;
      logic [7:0] b;
      k = $urandom_range(3);
      for (i = 0; i < 4; i++) begin
         b = MAGIC_WORD[i];
         if (i == k || $urandom_range(3) == 0) b = b ^ 8'($urandom_range(1, 255));
         send_byte(b);
      end
      repeat (4) send_byte(8'($urandom));
   endtask

   // Noise during the hunt, biased toward partial magic but never a full match.
   task automatic send_hunt_noise();
      int m;
      logic [7:0] b;
      m = 0;
      repeat ($urandom_range(6)) begin
         b = ($urandom_range(1) == 1) ? MAGIC_WORD[$urandom_range(3)] : 8'($urandom);
         if (m == 3 && b == MAGIC_WORD[3]) b = 8'h00;
         if (b == MAGIC_WORD[m]) m++;
         else m = (b == MAGIC_WORD[0]) ? 1 : 0;
         send_byte(b);
      end
   endtask

   function automatic logic [31:0] pick_size();
      int r, cap;
      r = $urandom_range(99);
      cap = (cur_max < 12) ? cur_max : 12;
      if (r < 70) return $urandom_range(1, cap);
      if (r < 80) return (cur_max < 48) ? $urandom_range(1, cur_max) : $urandom_range(1, 48);
      if (r < 88) return (cur_max <= 64) ? cur_max : $urandom_range(1, cap);
      if (r < 94) return ($urandom_range(1) == 1) ? 32'd0 : 32'(cur_max + 1);
      return {8'($urandom_range(1, 255)), 24'($urandom)};
   endfunction

   task automatic send_random_sequence();
      int kind;
      logic [31:0] size;
      kind = $urandom_range(99);
      size = pick_size();
      if (kind < 55) begin
         send_bytes({size, MAGIC_WORD}, 0, 8);
         send_body(size, ($urandom_range(9) == 0) ? int'($urandom_range(size - 1)) : -1);
         if ($urandom_range(7) == 0) send_eof();
      end else if (kind < 72) begin
         send_bad_header();
         send_hunt_noise();
         if ($urandom_range(9) == 0) begin
            send_eof();
         end else begin
            send_bytes({size, MAGIC_WORD}, 0, 4);
            if ($urandom_range(6) == 0) begin
               send_bytes({size, MAGIC_WORD}, 4, $urandom_range(3));
               send_eof();
            end else begin
               send_bytes({size, MAGIC_WORD}, 4, 4);
               send_body(size, -1);
            end
         end
      end else if (kind < 84) begin
         send_bytes({size, MAGIC_WORD}, 0, $urandom_range(1, 7));
         send_eof();
      end else if (kind < 92) begin
         repeat ($urandom_range(6)) send_byte(8'($urandom));
         send_eof();
      end else begin
         size = ($urandom_range(1) == 1) ? 32'(cur_max + 1) : {8'($urandom_range(1, 255)),
                                                               24'($urandom)};
         send_bytes({size, MAGIC_WORD}, 0, 8);
         send_body(size, -1);
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (checker_sb.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_max_size(input int value);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= SizeWidth'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_max = value;
      checker_sb.max_frame_size = SizeWidth'(value);
   endtask

   task automatic run_random(input int tx_pct, input int rx_pct, input int n_items);
      int target;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      target = items_sent + n_items;
      while (items_sent < target) send_random_sequence();
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      tx_idle_pct = 9;
      rx_idle_pct = 56;
      // Good frame of one byte, then a bad magic, a hunt with a repeated first
      // magic byte, a zero size and end of file while skipping.
      send_bytes({32'd1, MAGIC_WORD}, 0, 8);
      send_byte(8'hFF);
      send_bytes({32'hFFFF_FFFF, 8'h00, MAGIC_WORD[2:0]}, 0, 8);
      send_byte(MAGIC_WORD[0]);
      send_bytes({32'd0, MAGIC_WORD}, 0, 8);
      send_eof();

      write_max_size(1);
      run_random(9, 56, 40);

      write_max_size($urandom_range(8, 40));
      run_random(9, 56, 230);

      write_max_size(1048576);
      run_random(56, 9, 240);

      write_max_size($urandom_range(2, 40));
      hold_toggle = ~hold_toggle;
      run_random(0, 0, 240);

      wait_quiet();
      repeat (8) @(negedge clock);
      if (checker_sb.failures == 0 && checker_sb.outstanding() == 0) begin
         $display("tb_magic_length_frame_deframer_top: PASS");
      end else begin
         $display("tb_magic_length_frame_deframer_top: FAIL");
      end
      $finish;
   end

endmodule
